FILE: hdl/m4inv_pkg.sv
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared types, constants and index helpers for the 4x4 adjugate inverse core.
// ----------------------------------------------------------------------------
package m4inv_pkg;

  localparam int ELEM_W   = 16;
  localparam int COF_W    = 49;
  localparam int PROD_W   = 49;
  localparam int DACC_W   = 66;
  localparam int DMAG_W   = 65;
  localparam int REM_W    = 66;
  localparam int QUO_W    = 33;
  localparam int INV_W    = 32;
  localparam int DET_W    = 64;
  localparam int DIV_STEPS = 33;

  localparam logic [INV_W-1:0] ONE_Q16  = 32'h0001_0000;
  localparam logic [INV_W-1:0] INV_MAX  = 32'h7FFF_FFFF;
  localparam logic [INV_W-1:0] INV_MIN  = 32'h8000_0000;
  localparam logic [DET_W-1:0] DET_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DET_W-1:0] DET_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [2:0]       LAST_TERM = 3'd5;

  typedef enum logic [3:0] {
    ST_LOAD, ST_TA, ST_TB, ST_TC, ST_TD,
    ST_DLO, ST_DLOACC, ST_DHI, ST_DHIACC,
    ST_PREP, ST_DIVINIT, ST_DIVRUN, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_TA, OP_TB, OP_TC, OP_TD,
    OP_DLO, OP_DLOACC, OP_DHI, OP_DHIACC,
    OP_PREP, OP_DIVINIT, OP_DIVSTEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] idx;
    logic [2:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic singular;
  } dp_stat_t;

  // k-th of the three indices left once x is struck out
  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] x);
    skip_idx = (k < x) ? k : k + 2'd1;
  endfunction

  // column permutation of one 3x3 expansion term
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] j);
    logic [5:0] p;
    unique case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd2, 2'd0, 2'd1};
      default: p = {2'd0, 2'd1, 2'd2};
    endcase
    unique case (j)
      2'd0:    perm_col = p[1:0];
      2'd1:    perm_col = p[3:2];
      default: perm_col = p[5:4];
    endcase
  endfunction

  // odd permutations are terms three to five
  function automatic logic perm_neg(input logic [2:0] t);
    perm_neg = (t >= 3'd3);
  endfunction

endpackage

FILE: hdl/m4inv_ctrl.sv
// ----------------------------------------------------------------------------
// m4inv_ctrl
// Sequencer: load, cofactor terms, determinant, division and result hand-off.
// ----------------------------------------------------------------------------
module m4inv_ctrl import m4inv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctrl_state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [2:0]  term_r, term_nxt;
  logic [5:0]  iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      term_r  <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      term_r  <= term_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    term_nxt  = term_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_nxt = ST_TA;
            term_nxt  = '0;
          end
        end
      end
      ST_TA: state_nxt = ST_TB;
      ST_TB: state_nxt = ST_TC;
      ST_TC: state_nxt = ST_TD;
      ST_TD: begin
        if (term_r == LAST_TERM) begin
          term_nxt = '0;
          cnt_nxt  = cnt_r + 4'd1;
          state_nxt = (cnt_r == 4'd15) ? ST_DLO : ST_TA;
        end else begin
          term_nxt  = term_r + 3'd1;
          state_nxt = ST_TA;
        end
      end
      ST_DLO:    state_nxt = ST_DLOACC;
      ST_DLOACC: state_nxt = ST_DHI;
      ST_DHI:    state_nxt = ST_DHIACC;
      ST_DHIACC: begin
        if (cnt_r == 4'd3) begin
          cnt_nxt   = '0;
          state_nxt = ST_PREP;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = ST_DLO;
        end
      end
      ST_PREP: state_nxt = ST_DIVINIT;
      ST_DIVINIT: begin
        iter_nxt  = '0;
        state_nxt = stat.singular ? ST_EMIT : ST_DIVRUN;
      end
      ST_DIVRUN: begin
        iter_nxt = iter_r + 6'd1;
        if (iter_r == 6'(DIV_STEPS - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = (cnt_r == 4'd15) ? ST_LOAD : ST_DIVINIT;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    cmd.idx   = cnt_r;
    cmd.term  = term_r;
    cmd.op    = OP_IDLE;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_LOAD : OP_IDLE;
      end
      ST_TA:      cmd.op = OP_TA;
      ST_TB:      cmd.op = OP_TB;
      ST_TC:      cmd.op = OP_TC;
      ST_TD:      cmd.op = OP_TD;
      ST_DLO:     cmd.op = OP_DLO;
      ST_DLOACC:  cmd.op = OP_DLOACC;
      ST_DHI:     cmd.op = OP_DHI;
      ST_DHIACC:  cmd.op = OP_DHIACC;
      ST_PREP:    cmd.op = OP_PREP;
      ST_DIVINIT: cmd.op = OP_DIVINIT;
      ST_DIVRUN:  cmd.op = OP_DIVSTEP;
      ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = (cnt_r == 4'd15);
      end
      default: cmd.op = OP_IDLE;
    endcase
  end

endmodule

FILE: hdl/m4inv_dp.sv
// ----------------------------------------------------------------------------
// m4inv_dp
// Datapath: element store, shared 33x16 multiplier, cofactor and determinant
// accumulators, radix-2 divider and result formatting.
// ----------------------------------------------------------------------------
module m4inv_dp import m4inv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  input  logic signed [ELEM_W-1:0] element,
  output dp_stat_t                stat,
  output logic [INV_W-1:0]        inverse_element,
  output logic                    singular,
  output logic [DET_W-1:0]        determinant
);

  logic [ELEM_W-1:0] store_r [16];
  logic [COF_W-1:0]  cof_r   [16];
  logic [ELEM_W-1:0] a_r;
  logic [PROD_W-1:0] prod_r;
  logic [COF_W-1:0]  cacc_r;
  logic [DACC_W-1:0] dacc_r;
  logic [DET_W-1:0]  det_r;
  logic [DMAG_W-1:0] dmag_r;
  logic              dneg_r, sing_r;
  logic [REM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  sh_r, q_r;
  logic              ovf_r, neg_r;

  logic [1:0] row, col, sel_j, row_j, col_j;
  logic [3:0] st_addr, cof_addr;
  logic [ELEM_W-1:0] st_rd;
  logic [COF_W-1:0]  cof_rd, cof_mag, term_base, term_sum;
  logic              term_neg;
  logic signed [32:0] ma;
  logic signed [ELEM_W-1:0] mb;
  logic signed [PROD_W-1:0] mprod;
  logic [DACC_W-1:0] dacc_base, dacc_neg;
  logic              det_fits;
  logic [REM_W-1:0]  trial;
  logic              trial_ge;

  assign row = cmd.idx[3:2];
  assign col = cmd.idx[1:0];

  always_comb begin
    unique case (cmd.op)
      OP_TB:   sel_j = 2'd1;
      OP_TC:   sel_j = 2'd2;
      default: sel_j = 2'd0;
    endcase
  end

  assign row_j = skip_idx(sel_j, row);
  assign col_j = skip_idx(perm_col(cmd.term, sel_j), col);

  always_comb begin
    unique case (cmd.op)
      OP_TA, OP_TB, OP_TC: st_addr = {row_j, col_j};
      default:             st_addr = cmd.idx;
    endcase
  end

  assign st_rd    = store_r[st_addr];
  // result (r,c) uses cofactor (c,r)
  assign cof_addr = (cmd.op == OP_DIVINIT) ? {cmd.idx[1:0], cmd.idx[3:2]} : cmd.idx;
  assign cof_rd   = cof_r[cof_addr];
  assign cof_mag  = cof_rd[COF_W-1] ? (~cof_rd + COF_W'(1)) : cof_rd;

  always_comb begin
    unique case (cmd.op)
      OP_TB:   ma = {{17{a_r[ELEM_W-1]}}, a_r};
      OP_TC:   ma = {prod_r[31], prod_r[31:0]};
      OP_DLO:  ma = {1'b0, cof_rd[31:0]};
      OP_DHI:  ma = {{16{cof_rd[COF_W-1]}}, cof_rd[COF_W-1:32]};
      default: ma = '0;
    endcase
  end

  assign mb    = $signed(st_rd);
  assign mprod = ma * mb;

  assign term_neg  = perm_neg(cmd.term) ^ row[0] ^ col[0];
  assign term_base = (cmd.term == 3'd0) ? '0 : cacc_r;
  assign term_sum  = term_neg ? (term_base - prod_r) : (term_base + prod_r);

  assign dacc_base = (cmd.idx == 4'd0) ? '0 : dacc_r;
  assign dacc_neg  = ~dacc_r + DACC_W'(1);
  assign det_fits  = (dacc_r[65] == dacc_r[64]) && (dacc_r[64] == dacc_r[63]);

  assign trial    = {rem_r[REM_W-2:0], sh_r[QUO_W-1]};
  assign trial_ge = (trial >= {1'b0, dmag_r});

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD:   store_r[cmd.idx] <= element;
      OP_TA:     a_r <= st_rd;
      OP_TB:     prod_r <= mprod;
      OP_TC:     prod_r <= mprod;
      OP_TD: begin
        cacc_r <= term_sum;
        if (cmd.term == LAST_TERM) cof_r[cmd.idx] <= term_sum;
      end
      OP_DLO:    prod_r <= mprod;
      OP_DLOACC: dacc_r <= dacc_base + {{17{prod_r[PROD_W-1]}}, prod_r};
      OP_DHI:    prod_r <= mprod;
      OP_DHIACC: dacc_r <= dacc_r + {prod_r[33:0], 32'b0};
      OP_PREP: begin
        det_r  <= det_fits ? dacc_r[DET_W-1:0] : (dacc_r[65] ? DET_MIN : DET_MAX);
        dneg_r <= dacc_r[65];
        dmag_r <= dacc_r[65] ? dacc_neg[DMAG_W-1:0] : dacc_r[DMAG_W-1:0];
      end
      OP_DIVINIT: begin
        // quotient of 2^33 or more saturates either way
        ovf_r <= ({26'b0, cof_mag[47:9]} >= dmag_r);
        rem_r <= {27'b0, cof_mag[47:9]};
        sh_r  <= {cof_mag[8:0], 24'b0};
        q_r   <= '0;
        neg_r <= cof_rd[COF_W-1] ^ dneg_r;
      end
      OP_DIVSTEP: begin
        rem_r <= trial_ge ? (trial - {1'b0, dmag_r}) : trial;
        q_r   <= {q_r[QUO_W-2:0], trial_ge};
        sh_r  <= {sh_r[QUO_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sing_r <= 1'b0;
    end else if (cmd.op == OP_PREP) begin
      sing_r <= (dacc_r == '0);
    end
  end

  always_comb begin
    logic [INV_W-1:0] qneg;
    qneg = ~q_r[INV_W-1:0] + INV_W'(1);
    priority if (sing_r) begin
      inverse_element = (cmd.idx[3:2] == cmd.idx[1:0]) ? ONE_Q16 : '0;
    end else if (!neg_r) begin
      inverse_element = (ovf_r || q_r > {1'b0, INV_MAX}) ? INV_MAX : q_r[INV_W-1:0];
    end else begin
      inverse_element = (ovf_r || q_r > {1'b0, INV_MIN}) ? INV_MIN : qneg;
    end
  end

  assign singular      = sing_r;
  assign determinant   = det_r;
  assign stat.singular = sing_r;

endmodule

FILE: hdl/matrix4_inverse_adjugate_core.sv
// ----------------------------------------------------------------------------
// matrix4_inverse_adjugate_core
// 4x4 matrix inverse by adjugate: load 16 Q8.8 elements, emit 16 Q16.16.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                | tuser    | tlast
//  in_     | in  | [15:0] element                       | -        | -
//  out_    | out | [31:0] inverse_element, [95:32] det  | singular | last
//
// Loading takes one element per cycle while in_tvalid is high. Cofactors come
// from 96 triple products, each through states TA to TD on the shared
// multiplier, then the determinant and a setup step. Each result needs a setup
// step, the radix-2 divider (skipped if singular) and a step to present it.
// Input is not taken while a matrix is being worked on; a stalled out_tready
// holds the current result. Synchronous active-low reset returns to loading.
// ----------------------------------------------------------------------------
module matrix4_inverse_adjugate_core import m4inv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] inverse_element, [95:32] determinant
  output logic        out_tuser,  // [0] singular
  output logic        out_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [INV_W-1:0] inv_el;
  logic [DET_W-1:0] det;

  m4inv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_last  (out_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

  m4inv_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .element         ($signed(in_tdata)),
    .stat            (stat),
    .inverse_element (inv_el),
    .singular        (out_tuser),
    .determinant     (det)
  );

  assign out_tdata = {det, inv_el};

endmodule

FILE: test/matrix4_inverse_adjugate_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix4_inverse_adjugate_core_tb
// Streams 4x4 Q8.8 matrices into the core and checks every Q16.16 inverse
// element, singular flag, determinant and tlast against a behavioural
// adjugate predictor, with random idling on both sides and a long out stall.
// ----------------------------------------------------------------------------
module matrix4_inverse_adjugate_core_tb;
  import m4inv_pkg::*;

  typedef struct {
    logic [31:0] inv;
    logic        sing;
    logic [63:0] det;
    logic        last;
  } inv_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic [15:0] element_queue[$];
  inv_result_t inverse_queue[$];
  logic signed [15:0] mat_store[16];
  int  load_cnt = 0;
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cycles = 0;
  bit  stim_done = 1'b0;
  bit  in_taken = 1'b0;

  matrix4_inverse_adjugate_core DUT (.*);

  always #5 clk = ~clk;

  function automatic logic signed [63:0] minor3(int row, int col);
    logic signed [63:0] m[3][3];
    int mr, mc;
    mr = 0;
    for (int r = 0; r < 4; r++) begin
      if (r == row) continue;
      mc = 0;
      for (int c = 0; c < 4; c++) begin
        if (c == col) continue;
        m[mr][mc] = mat_store[r*4+c];
        mc++;
      end
      mr++;
    end
    return m[0][0]*(m[1][1]*m[2][2]-m[1][2]*m[2][1])
         - m[0][1]*(m[1][0]*m[2][2]-m[1][2]*m[2][0])
         + m[0][2]*(m[1][0]*m[2][1]-m[1][1]*m[2][0]);
  endfunction

  task automatic predict_inverse();
    logic signed [63:0]  cof[4][4];
    logic signed [127:0] det;
    logic [127:0]        dmag, num, quo;
    logic [63:0]         det_bits;
    logic                sing, neg;
    logic signed [63:0]  cv;
    inv_result_t         res;
    det = '0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        cof[r][c] = minor3(r, c);
        if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
      end
    for (int c = 0; c < 4; c++)
      det += 128'(signed'(mat_store[c])) * 128'(cof[0][c]);
    sing = (det == 0);
    if (det > 128'sh7FFF_FFFF_FFFF_FFFF) det_bits = DET_MAX;
    else if (det < -128'sh8000_0000_0000_0000) det_bits = DET_MIN;
    else det_bits = det[63:0];
    dmag = det < 0 ? -det : det;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (sing) begin
          res.inv = (r == c) ? ONE_Q16 : '0;
        end else begin
          cv  = cof[c][r];
          neg = (cv < 0) != (det < 0);
          num = (cv < 0 ? 128'(-cv) : 128'(cv)) << 24;
          quo = num / dmag;
          if (!neg) res.inv = quo > 128'h7FFF_FFFF ? INV_MAX : quo[31:0];
          else res.inv = quo > 128'h8000_0000 ? INV_MIN : -quo[31:0];
        end
        res.sing = sing;
        res.det  = det_bits;
        res.last = (r == 3 && c == 3);
        inverse_queue.push_back(res);
      end
  endtask

  // input transfers are taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      mat_store[load_cnt] = in_tdata;
      if (load_cnt == 15) begin
        load_cnt = 0;
        predict_inverse();
      end else begin
        load_cnt++;
      end
      in_taken = 1'b1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (element_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= element_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with its own hold-off count
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    inv_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (inverse_queue.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_r = inverse_queue.pop_front();
        if (out_tdata[31:0] !== exp_r.inv) begin
          $error("inverse_element exp %h got %h", exp_r.inv, out_tdata[31:0]);
          errors++;
        end
        if (out_tuser !== exp_r.sing) begin
          $error("singular exp %b got %b", exp_r.sing, out_tuser);
          errors++;
        end
        if (out_tdata[95:32] !== exp_r.det) begin
          $error("determinant exp %h got %h", exp_r.det, out_tdata[95:32]);
          errors++;
        end
        if (out_tlast !== exp_r.last) begin
          $error("last exp %b got %b", exp_r.last, out_tlast);
          errors++;
        end
      end
    end
  end

  task automatic push_matrix(input logic [15:0] m[16]);
    for (int i = 0; i < 16; i++) element_queue.push_back(m[i]);
  endtask

  task automatic push_random_matrix(int kind);
    logic [15:0] m[16];
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: m[i] = $urandom;                                  // full range
        1: m[i] = 16'($signed($urandom_range(1024)) - 512);  // moderate
        2: m[i] = (i % 5 == 0) ? 16'($urandom_range(1024) + 64)
                               : 16'($signed($urandom_range(64)) - 32);
        default: m[i] = 16'($signed($urandom_range(8)) - 4);  // often singular
      endcase
    end
    if (kind == 1 && $urandom_range(5) == 0)  // duplicated row: singular
      for (int c = 0; c < 4; c++) m[12+c] = m[c];
    push_matrix(m);
  endtask

  task automatic drain();
    while (element_queue.size() > 0 || in_tvalid || inverse_queue.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    logic [15:0] m[16];
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // identity, scaled diagonal, all zero, extreme elements
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 16'h0100 : 16'h0000;
    push_matrix(m);
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 16'h0001 : 16'h0000;
    push_matrix(m);   // tiny determinant: diagonal quotients of 256.0
    for (int i = 0; i < 16; i++) m[i] = '0;
    push_matrix(m);
    for (int i = 0; i < 16; i++)
      m[i] = (i % 5 == 0) ? 16'h8000 : ((i == 1 || i == 11) ? 16'h7FFF : 16'h0000);
    push_matrix(m);   // determinant 2^60
    for (int i = 0; i < 16; i++)
      m[i] = (i % 5 == 0) ? 16'h8000 : ((i % 4 == 3 - i / 4) ? 16'h8000 : 16'h7FFF);
    push_matrix(m);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 18 : 0;
      recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 18 : 0;
      if (ph == 2) hold_cycles = 3000;  // long hold-off: core fills and stalls
      for (int k = 0; k < 4; k++) push_random_matrix($urandom_range(3));
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/m4inv_pkg.sv
hdl/m4inv_ctrl.sv
hdl/m4inv_dp.sv
hdl/matrix4_inverse_adjugate_core.sv
test/matrix4_inverse_adjugate_core_tb.sv
